// ===== design/hstm_pkg.sv =====
package hstm_pkg;

    // Sequencer steps; the six start-pattern phases are consecutive codes.
    typedef enum logic [4:0] {
        ST_IDLE    = 5'd0,
        ST_RST_HI  = 5'd1,
        ST_RST_LO  = 5'd2,
        ST_START0  = 5'd3,
        ST_START1  = 5'd4,
        ST_START2  = 5'd5,
        ST_START3  = 5'd6,
        ST_START4  = 5'd7,
        ST_START5  = 5'd8,
        ST_WBIT_A  = 5'd9,
        ST_WBIT_B  = 5'd10,
        ST_WBIT_C  = 5'd11,
        ST_ACK_HI  = 5'd12,
        ST_ACK_LO  = 5'd13,
        ST_WAIT    = 5'd14,
        ST_RBIT_HI = 5'd15,
        ST_RBIT_LO = 5'd16,
        ST_MACK_A  = 5'd17,
        ST_MACK_B  = 5'd18,
        ST_MACK_C  = 5'd19
    } t_step;

    typedef enum logic [2:0] {
        CMD_TEMP     = 3'd0,
        CMD_HUMID    = 3'd1,
        CMD_RD_STAT  = 3'd2,
        CMD_WR_STAT  = 3'd3,
        CMD_SOFT_RST = 3'd4
    } t_cmd;

    // Configuration register indexes.
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_WAIT_LIMIT  = 1'b1;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd1;
    localparam logic [15:0] WAIT_LIMIT_RST  = 16'd500;

    // Command bytes sent on the wire.
    localparam logic [7:0] CODE_TEMP     = 8'h03;
    localparam logic [7:0] CODE_HUMID    = 8'h05;
    localparam logic [7:0] CODE_RD_STAT  = 8'h07;
    localparam logic [7:0] CODE_WR_STAT  = 8'h06;
    localparam logic [7:0] CODE_SOFT_RST = 8'h1E;

    localparam logic [3:0] RESET_CLOCKS = 4'd9;
    localparam logic [3:0] BYTE_BITS    = 4'd8;

    // Humidity compensation.
    localparam logic [7:0]  HUM_KNEE     = 8'd107;
    localparam logic [7:0]  HUM_SLOPE_LO = 8'd143;
    localparam logic [15:0] HUM_FLOOR    = 16'd512;
    localparam logic [7:0]  HUM_SLOPE_HI = 8'd111;
    localparam logic [15:0] HUM_OFFSET   = 16'd2893;
    localparam logic [15:0] HUM_CEIL     = 16'd25600;

    // Temperature: x / 25 as (x * 83887) >> 21, exact for all 16-bit x.
    localparam logic [16:0] TEMP_RECIP   = 17'd83887;
    localparam int          TEMP_SHIFT   = 21;
    localparam logic [7:0]  TEMP_OFFSET  = 8'd40;

    typedef struct packed {
        logic       ready_timeout;
        logic       ack_error;
        logic [7:0] value;
        logic       done_res;
        logic       busy_res;
        logic       data_drive_low;
        logic       sck;
    } t_result;

    function automatic logic [7:0] cmd_code(input logic [2:0] cmd);
        logic [7:0] code;
        case (cmd)
            CMD_TEMP:     code = CODE_TEMP;
            CMD_HUMID:    code = CODE_HUMID;
            CMD_RD_STAT:  code = CODE_RD_STAT;
            CMD_WR_STAT:  code = CODE_WR_STAT;
            CMD_SOFT_RST: code = CODE_SOFT_RST;
            default:      code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// ===== design/humidity_sensor_two_wire_master.sv =====
// Channel   Dir  Handshake               Payload
// s (tick)  in   i_s_tvalid/o_s_tready   tuser: action; tdata: command, write_data, data_in
// m (state) out  o_m_tvalid/i_m_tready   tdata: sck, data_drive_low, busy, done, value, flags
// cfg       in   i_cfg_we                i_cfg_index, i_cfg_data
//
// Every accepted transfer, a tick or a start, yields exactly one result transfer.
// One transfer per clock: the sequencer updates in the accept cycle and its result
// lands in the output register, so a new tick is taken while a result waits
// as long as the downstream side takes that result in the same cycle.
// The temperature reciprocal multiply sits between the byte registers and
// the output register. Synchronous active-low reset returns the sequencer to
// idle with phase_ticks 1 and ready_wait_limit 500.
module humidity_sensor_two_wire_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic        i_s_tuser,   // [0] action
    input  logic [15:0] i_s_tdata,   // [2:0] command, [10:3] write_data, [11] data_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] sck, [1] data_drive_low, [2] busy_res, [3] done_res, [11:4] value,
    // [12] ack_error, [13] ready_timeout
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_phase_ticks;
    logic [15:0] r_wait_limit;

    hstm_pkg::t_step   r_step, n_step;
    logic [15:0]       r_phase, n_phase;
    logic [3:0]        r_bit, n_bit;
    logic [7:0]        r_shift, n_shift;
    logic [1:0]        r_byte_idx, n_byte_idx;
    logic [7:0]        r_first, n_first;
    logic [7:0]        r_second, n_second;
    logic [15:0]       r_wait, n_wait;
    logic [2:0]        r_cmd, n_cmd;
    logic [7:0]        r_held, n_held;
    logic [1:0]        r_err, n_err;

    logic              r_out_valid;
    hstm_pkg::t_result r_out, n_out;

    logic        accept;
    logic        in_action;
    logic [2:0]  in_cmd;
    logic [7:0]  in_wdata;
    logic        in_din;
    logic        n_done;
    logic [15:0] phase_inc;
    logic [15:0] wait_inc;
    logic [3:0]  bit_inc;
    logic [1:0]  last_idx;
    logic [1:0]  n_last_idx;
    logic [7:0]  conv_value;
    logic        lvl_sck;
    logic        lvl_low;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_action  = i_s_tuser;
    assign in_cmd     = i_s_tdata[2:0];
    assign in_wdata   = i_s_tdata[10:3];
    assign in_din     = i_s_tdata[11];

    assign phase_inc  = r_phase + 16'd1;
    assign wait_inc   = r_wait + 16'd1;
    assign bit_inc    = r_bit + 4'd1;
    assign last_idx   = (r_cmd == hstm_pkg::CMD_RD_STAT) ? 2'd1 : 2'd2;
    assign n_last_idx = (n_cmd == hstm_pkg::CMD_RD_STAT) ? 2'd1 : 2'd2;

    hstm_convert u_convert (
        .i_cmd         (r_cmd),
        .i_first_byte  (r_first),
        .i_second_byte (r_second),
        .o_value       (conv_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= hstm_pkg::PHASE_TICKS_RST;
            r_wait_limit  <= hstm_pkg::WAIT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hstm_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                hstm_pkg::CFG_WAIT_LIMIT:  r_wait_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= hstm_pkg::ST_IDLE;
            r_phase     <= 16'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_byte_idx  <= 2'd0;
            r_first     <= 8'd0;
            r_second    <= 8'd0;
            r_wait      <= 16'd0;
            r_cmd       <= 3'd0;
            r_held      <= 8'd0;
            r_err       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_byte_idx <= n_byte_idx;
            r_first    <= n_first;
            r_second   <= n_second;
            r_wait     <= n_wait;
            r_cmd      <= n_cmd;
            r_held     <= n_held;
            r_err      <= n_err;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // Sequencer: one tick per accepted tick transfer; an accepted start launches a command from idle.
    always_comb begin
        n_step     = r_step;
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_byte_idx = r_byte_idx;
        n_first    = r_first;
        n_second   = r_second;
        n_wait     = r_wait;
        n_cmd      = r_cmd;
        n_held     = r_held;
        n_err      = r_err;
        n_done     = 1'b0;

        if (accept) begin
            if (in_action) begin
                if (r_step == hstm_pkg::ST_IDLE && in_cmd <= hstm_pkg::CMD_SOFT_RST) begin
                    n_cmd      = in_cmd;
                    n_held     = in_wdata;
                    n_shift    = hstm_pkg::cmd_code(in_cmd);
                    n_err      = 2'd0;
                    n_phase    = 16'd0;
                    n_bit      = 4'd0;
                    n_byte_idx = 2'd0;
                    n_wait     = 16'd0;
                    n_step     = (in_cmd == hstm_pkg::CMD_SOFT_RST) ?
                                 hstm_pkg::ST_RST_HI : hstm_pkg::ST_START0;
                end
            end else if (r_step != hstm_pkg::ST_IDLE) begin
                n_phase = phase_inc;
                if (phase_inc >= r_phase_ticks) begin
                    n_phase = 16'd0;
                    case (r_step)
                        hstm_pkg::ST_START0, hstm_pkg::ST_START1, hstm_pkg::ST_START2,
                        hstm_pkg::ST_START3, hstm_pkg::ST_START4: begin
                            n_step = hstm_pkg::t_step'(5'(r_step) + 5'd1);
                        end
                        hstm_pkg::ST_RST_HI: n_step = hstm_pkg::ST_RST_LO;
                        hstm_pkg::ST_RST_LO: begin
                            if (bit_inc >= hstm_pkg::RESET_CLOCKS) begin
                                n_bit  = 4'd0;
                                n_step = hstm_pkg::ST_START0;
                            end else begin
                                n_bit  = bit_inc;
                                n_step = hstm_pkg::ST_RST_HI;
                            end
                        end
                        hstm_pkg::ST_START5: begin
                            n_bit  = 4'd0;
                            n_step = hstm_pkg::ST_WBIT_A;
                        end
                        hstm_pkg::ST_WBIT_A: n_step = hstm_pkg::ST_WBIT_B;
                        hstm_pkg::ST_WBIT_B: n_step = hstm_pkg::ST_WBIT_C;
                        hstm_pkg::ST_WBIT_C: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            if (bit_inc >= hstm_pkg::BYTE_BITS) begin
                                n_bit  = 4'd0;
                                n_step = hstm_pkg::ST_ACK_HI;
                            end else begin
                                n_bit  = bit_inc;
                                n_step = hstm_pkg::ST_WBIT_A;
                            end
                        end
                        hstm_pkg::ST_ACK_HI: begin
                            if (in_din) begin
                                n_err[0] = 1'b1;
                            end
                            n_step = hstm_pkg::ST_ACK_LO;
                        end
                        hstm_pkg::ST_ACK_LO: begin
                            case (r_cmd)
                                hstm_pkg::CMD_WR_STAT: begin
                                    if (r_byte_idx == 2'd0) begin
                                        n_byte_idx = 2'd1;
                                        n_shift    = r_held;
                                        n_step     = hstm_pkg::ST_WBIT_A;
                                    end else begin
                                        n_done = 1'b1;
                                        n_step = hstm_pkg::ST_IDLE;
                                    end
                                end
                                hstm_pkg::CMD_RD_STAT: begin
                                    n_byte_idx = 2'd0;
                                    n_bit      = 4'd0;
                                    n_shift    = 8'd0;
                                    n_step     = hstm_pkg::ST_RBIT_HI;
                                end
                                hstm_pkg::CMD_TEMP, hstm_pkg::CMD_HUMID: begin
                                    n_wait = 16'd0;
                                    n_step = hstm_pkg::ST_WAIT;
                                end
                                default: begin
                                    n_done = 1'b1;
                                    n_step = hstm_pkg::ST_IDLE;
                                end
                            endcase
                        end
                        hstm_pkg::ST_WAIT: begin
                            // Data low means the conversion is ready; a timeout reads anyway.
                            if (!in_din) begin
                                n_byte_idx = 2'd0;
                                n_bit      = 4'd0;
                                n_shift    = 8'd0;
                                n_step     = hstm_pkg::ST_RBIT_HI;
                            end else begin
                                n_wait = wait_inc;
                                if (wait_inc >= r_wait_limit) begin
                                    n_err[1]   = 1'b1;
                                    n_byte_idx = 2'd0;
                                    n_bit      = 4'd0;
                                    n_shift    = 8'd0;
                                    n_step     = hstm_pkg::ST_RBIT_HI;
                                end
                            end
                        end
                        hstm_pkg::ST_RBIT_HI: begin
                            n_shift = {r_shift[6:0], in_din};
                            n_step  = hstm_pkg::ST_RBIT_LO;
                        end
                        hstm_pkg::ST_RBIT_LO: begin
                            if (bit_inc >= hstm_pkg::BYTE_BITS) begin
                                n_bit = 4'd0;
                                if (r_byte_idx == 2'd0) begin
                                    n_first = r_shift;
                                end else if (r_byte_idx == 2'd1) begin
                                    n_second = r_shift;
                                end
                                n_step = hstm_pkg::ST_MACK_A;
                            end else begin
                                n_bit  = bit_inc;
                                n_step = hstm_pkg::ST_RBIT_HI;
                            end
                        end
                        hstm_pkg::ST_MACK_A: n_step = hstm_pkg::ST_MACK_B;
                        hstm_pkg::ST_MACK_B: n_step = hstm_pkg::ST_MACK_C;
                        hstm_pkg::ST_MACK_C: begin
                            if (r_byte_idx >= last_idx) begin
                                n_done = 1'b1;
                                n_step = hstm_pkg::ST_IDLE;
                            end else begin
                                n_byte_idx = r_byte_idx + 2'd1;
                                n_shift    = 8'd0;
                                n_step     = hstm_pkg::ST_RBIT_HI;
                            end
                        end
                        default: n_step = hstm_pkg::ST_IDLE;
                    endcase
                end
            end
        end
    end

    // Wire levels for the step the sequencer has just entered.
    always_comb begin
        lvl_sck = 1'b0;
        lvl_low = 1'b0;
        case (n_step)
            hstm_pkg::ST_START0: begin lvl_sck = 1'b1; lvl_low = 1'b0; end
            hstm_pkg::ST_START1: begin lvl_sck = 1'b1; lvl_low = 1'b1; end
            hstm_pkg::ST_START2: begin lvl_sck = 1'b0; lvl_low = 1'b1; end
            hstm_pkg::ST_START3: begin lvl_sck = 1'b1; lvl_low = 1'b1; end
            hstm_pkg::ST_START4: begin lvl_sck = 1'b1; lvl_low = 1'b0; end
            hstm_pkg::ST_START5: begin lvl_sck = 1'b0; lvl_low = 1'b0; end
            hstm_pkg::ST_RST_HI, hstm_pkg::ST_ACK_HI, hstm_pkg::ST_RBIT_HI: begin
                lvl_sck = 1'b1;
            end
            hstm_pkg::ST_WBIT_A, hstm_pkg::ST_WBIT_B, hstm_pkg::ST_WBIT_C: begin
                lvl_sck = (n_step == hstm_pkg::ST_WBIT_B);
                lvl_low = !n_shift[7];
            end
            hstm_pkg::ST_MACK_A, hstm_pkg::ST_MACK_B, hstm_pkg::ST_MACK_C: begin
                // The last byte read is not acknowledged.
                lvl_sck = (n_step == hstm_pkg::ST_MACK_B);
                lvl_low = (n_byte_idx < n_last_idx);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out.sck            = lvl_sck;
        n_out.data_drive_low = lvl_low;
        n_out.busy_res       = (n_step != hstm_pkg::ST_IDLE);
        n_out.done_res       = n_done;
        n_out.value          = n_done ? conv_value : 8'd0;
        n_out.ack_error      = n_err[0];
        n_out.ready_timeout  = n_err[1];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out};

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res && r_step == hstm_pkg::ST_IDLE)
        else $error("done result reported while the sequencer is still running");

    a_wait_only_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == hstm_pkg::ST_WAIT |->
            (r_cmd == hstm_pkg::CMD_TEMP || r_cmd == hstm_pkg::CMD_HUMID))
        else $error("ready wait entered by a non-measurement command");

    a_counts_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= hstm_pkg::RESET_CLOCKS && r_byte_idx <= 2'd2)
        else $error("bit or byte counter out of range");

    a_start_clears_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_action && r_step == hstm_pkg::ST_IDLE &&
        in_cmd <= hstm_pkg::CMD_SOFT_RST |=> r_err == 2'd0 && r_step != hstm_pkg::ST_IDLE)
        else $error("accepted start did not launch a clean operation");

    a_tick_leaves_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted tick produced no result");

endmodule

// ===== design/hstm_convert.sv =====
module hstm_convert (
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_first_byte,
    input  logic [7:0] i_second_byte,
    output logic [7:0] o_value
);

    logic [15:0] reading;
    logic [32:0] temp_prod;
    logic [7:0]  temp_val;
    logic [15:0] hum_lo;
    logic [15:0] hum_hi;
    logic [15:0] hum_r;

    assign reading   = {i_first_byte, i_second_byte};
    assign temp_prod = 33'(reading) * 33'(hstm_pkg::TEMP_RECIP);
    assign temp_val  = temp_prod[hstm_pkg::TEMP_SHIFT +: 8] - hstm_pkg::TEMP_OFFSET;

    assign hum_lo = 16'(i_second_byte) * 16'(hstm_pkg::HUM_SLOPE_LO);
    assign hum_hi = 16'(i_second_byte) * 16'(hstm_pkg::HUM_SLOPE_HI)
                    + hstm_pkg::HUM_OFFSET;

    always_comb begin
        if (i_second_byte <= hstm_pkg::HUM_KNEE) begin
            hum_r = (hum_lo < hstm_pkg::HUM_FLOOR) ? 16'd0 : hum_lo - hstm_pkg::HUM_FLOOR;
        end else begin
            hum_r = (hum_hi > hstm_pkg::HUM_CEIL) ? hstm_pkg::HUM_CEIL : hum_hi;
        end
    end

    always_comb begin
        case (i_cmd)
            hstm_pkg::CMD_TEMP:    o_value = temp_val;
            hstm_pkg::CMD_HUMID:   o_value = hum_r[15:8];
            hstm_pkg::CMD_RD_STAT: o_value = i_first_byte;
            default:               o_value = 8'd0;
        endcase
    end

endmodule

// ===== verif/humidity_sensor_two_wire_master_tb.sv =====
module humidity_sensor_two_wire_master_tb;
    import hstm_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;

    // Start pattern levels, indexed by the phase within the pattern.
    localparam logic [5:0] START_SCK = 6'b011011;
    localparam logic [5:0] START_LOW = 6'b001110;

    localparam logic [7:0] CMD_BYTES [0:4] = '{CODE_TEMP, CODE_HUMID, CODE_RD_STAT,
                                               CODE_WR_STAT, CODE_SOFT_RST};

    // Second-byte readings around the floor, the knee and the ceiling of the humidity curve.
    localparam logic [7:0] HUM_PROBES [0:7] = '{8'd0, 8'd3, 8'd4, HUM_KNEE, HUM_KNEE + 8'd1,
                                                8'd204, 8'd205, 8'd255};

    typedef struct packed {
        logic       action;
        logic [2:0] cmd;
        logic [7:0] wdata;
        logic       din;
    } t_tick;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [15:0] wait_limit;
        t_step       step;
        logic [15:0] phase_cnt;
        logic [3:0]  bit_cnt;
        logic [7:0]  shreg;
        logic [1:0]  byte_idx;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [15:0] wait_cnt;
        t_cmd        cmd;
        logic [7:0]  wr_byte;
        logic [1:0]  flags;
    } t_master;

    typedef enum logic [1:0] {RX_OPEN, RX_SPOTTY, RX_BLOCKS} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic        i_s_tuser = 1'b0;
    logic [15:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    humidity_sensor_two_wire_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // master_now follows the accepted ticks; master_plan runs ahead while ticks are queued.
    t_master     master_now;
    t_master     master_plan;
    t_tick       tick_q[$];
    t_result     want_levels_q[$];
    t_tick       drv_tick;
    t_result     next_levels;
    t_result     mon_want;
    t_result     mon_got;
    int          planned = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;
    int          rx_stall_left = 0;

    // Behavior of the simulated sensor during the operation being planned.
    logic [7:0]  sensor_bytes [0:2];
    int          nack_pct = 0;
    logic [15:0] ready_after = '0;

    function automatic t_result advance_master(inout t_master m, input t_tick t);
        t_result    r;
        logic       done;
        logic       to_read;
        logic [1:0] last_idx;
        logic [2:0] pat;
        int         hum;
        int         deg;
        r = '0;
        done = 1'b0;
        to_read = 1'b0;
        if (t.action) begin
            if (m.step == ST_IDLE && t.cmd <= CMD_SOFT_RST) begin
                m.cmd = t_cmd'(t.cmd);
                m.wr_byte = t.wdata;
                m.shreg = CMD_BYTES[t.cmd];
                m.flags = '0;
                m.phase_cnt = '0;
                m.bit_cnt = '0;
                m.byte_idx = '0;
                m.wait_cnt = '0;
                m.step = (t.cmd == CMD_SOFT_RST) ? ST_RST_HI : ST_START0;
            end
        end
        // Status reads stop after two bytes, measurements after three.
        last_idx = (m.cmd == CMD_RD_STAT) ? 2'd1 : 2'd2;
        if (!t.action && m.step != ST_IDLE) begin
            m.phase_cnt = m.phase_cnt + 16'd1;
            if (m.phase_cnt >= m.phase_ticks) begin
                m.phase_cnt = '0;
                if (m.step >= ST_START0 && m.step < ST_START5) begin
                    m.step = t_step'(m.step + 5'd1);
                end else begin
                    case (m.step)
                        ST_RST_HI: m.step = ST_RST_LO;
                        ST_RST_LO: begin
                            m.bit_cnt = m.bit_cnt + 4'd1;
                            if (m.bit_cnt >= RESET_CLOCKS) begin
                                m.bit_cnt = '0;
                                m.step = ST_START0;
                            end else begin
                                m.step = ST_RST_HI;
                            end
                        end
                        ST_START5: begin
                            m.bit_cnt = '0;
                            m.step = ST_WBIT_A;
                        end
                        ST_WBIT_A: m.step = ST_WBIT_B;
                        ST_WBIT_B: m.step = ST_WBIT_C;
                        ST_WBIT_C: begin
                            m.shreg = {m.shreg[6:0], 1'b0};
                            m.bit_cnt = m.bit_cnt + 4'd1;
                            if (m.bit_cnt >= BYTE_BITS) begin
                                m.bit_cnt = '0;
                                m.step = ST_ACK_HI;
                            end else begin
                                m.step = ST_WBIT_A;
                            end
                        end
                        ST_ACK_HI: begin
                            if (t.din) m.flags[0] = 1'b1;
                            m.step = ST_ACK_LO;
                        end
                        ST_ACK_LO: begin
                            if (m.cmd == CMD_WR_STAT && m.byte_idx == 2'd0) begin
                                m.byte_idx = 2'd1;
                                m.shreg = m.wr_byte;
                                m.step = ST_WBIT_A;
                            end else if (m.cmd == CMD_RD_STAT) begin
                                to_read = 1'b1;
                            end else if (m.cmd == CMD_TEMP || m.cmd == CMD_HUMID) begin
                                m.wait_cnt = '0;
                                m.step = ST_WAIT;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        ST_WAIT: begin
                            if (!t.din) begin
                                to_read = 1'b1;
                            end else begin
                                m.wait_cnt = m.wait_cnt + 16'd1;
                                if (m.wait_cnt >= m.wait_limit) begin
                                    m.flags[1] = 1'b1;
                                    to_read = 1'b1;
                                end
                            end
                        end
                        ST_RBIT_HI: begin
                            m.shreg = {m.shreg[6:0], t.din};
                            m.step = ST_RBIT_LO;
                        end
                        ST_RBIT_LO: begin
                            m.bit_cnt = m.bit_cnt + 4'd1;
                            if (m.bit_cnt >= BYTE_BITS) begin
                                m.bit_cnt = '0;
                                if (m.byte_idx == 2'd0) m.byte0 = m.shreg;
                                else if (m.byte_idx == 2'd1) m.byte1 = m.shreg;
                                m.step = ST_MACK_A;
                            end else begin
                                m.step = ST_RBIT_HI;
                            end
                        end
                        ST_MACK_A: m.step = ST_MACK_B;
                        ST_MACK_B: m.step = ST_MACK_C;
                        ST_MACK_C: begin
                            if (m.byte_idx >= last_idx) begin
                                done = 1'b1;
                            end else begin
                                m.byte_idx = m.byte_idx + 2'd1;
                                m.shreg = '0;
                                m.step = ST_RBIT_HI;
                            end
                        end
                        default: m.step = ST_IDLE;
                    endcase
                end
                if (to_read) begin
                    m.byte_idx = '0;
                    m.bit_cnt = '0;
                    m.shreg = '0;
                    m.step = ST_RBIT_HI;
                end
                if (done) begin
                    case (m.cmd)
                        CMD_RD_STAT: r.value = m.byte0;
                        CMD_HUMID: begin
                            if (m.byte1 <= HUM_KNEE) begin
                                hum = int'(HUM_SLOPE_LO) * int'(m.byte1);
                                hum = (hum < int'(HUM_FLOOR)) ? 0 : hum - int'(HUM_FLOOR);
                            end else begin
                                hum = int'(HUM_SLOPE_HI) * int'(m.byte1) + int'(HUM_OFFSET);
                                if (hum > int'(HUM_CEIL)) hum = int'(HUM_CEIL);
                            end
                            r.value = hum[15:8];
                        end
                        CMD_TEMP: begin
                            deg = int'({m.byte0, m.byte1}) / 25 - int'(TEMP_OFFSET);
                            r.value = deg[7:0];
                        end
                        default: r.value = '0;
                    endcase
                    m.step = ST_IDLE;
                end
            end
        end
        if (m.step >= ST_START0 && m.step <= ST_START5) begin
            pat = 3'(m.step - ST_START0);
            r.sck = START_SCK[pat];
            r.data_drive_low = START_LOW[pat];
        end else begin
            case (m.step)
                ST_RST_HI, ST_ACK_HI, ST_RBIT_HI: r.sck = 1'b1;
                ST_WBIT_A, ST_WBIT_B, ST_WBIT_C: begin
                    r.sck = (m.step == ST_WBIT_B);
                    r.data_drive_low = ~m.shreg[7];
                end
                ST_MACK_A, ST_MACK_B, ST_MACK_C: begin
                    r.sck = (m.step == ST_MACK_B);
                    r.data_drive_low = (m.byte_idx < last_idx);
                end
                default: ;
            endcase
        end
        r.busy_res = (m.step != ST_IDLE);
        r.done_res = done;
        r.ack_error = m.flags[0];
        r.ready_timeout = m.flags[1];
        return r;
    endfunction

    // Level the sensor puts on the data line for the next tick of the planned operation.
    function automatic logic sensor_level();
        logic lvl;
        case (master_plan.step)
            ST_ACK_HI:  lvl = ($urandom_range(1, 100) <= nack_pct);
            ST_WAIT:    lvl = (master_plan.wait_cnt < ready_after);
            ST_RBIT_HI: lvl = sensor_bytes[master_plan.byte_idx][3'd7 - master_plan.bit_cnt[2:0]];
            default:    lvl = 1'($urandom);
        endcase
        if ($urandom_range(0, 99) == 0) lvl = ~lvl;
        return lvl;
    endfunction

    function automatic t_tick wire_tick();
        t_tick t;
        t.action = 1'b0;
        t.cmd = 3'($urandom);
        t.wdata = 8'($urandom);
        t.din = sensor_level();
        return t;
    endfunction

    function automatic logic [7:0] pick_reading();
        if ($urandom_range(0, 2) == 0) return HUM_PROBES[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    task automatic plan_tick(input t_tick t);
        tick_q.push_back(t);
        void'(advance_master(master_plan, t));
        planned++;
    endtask

    task automatic plan_start(input logic [2:0] cmd, input logic [7:0] wdata);
        t_tick t;
        t.action = 1'b1;
        t.cmd = cmd;
        t.wdata = wdata;
        t.din = 1'($urandom);
        plan_tick(t);
    endtask

    // Runs the planned operation to its end, now and then with a start that must be ignored.
    task automatic plan_to_idle();
        while (master_plan.step != ST_IDLE) begin
            if ($urandom_range(0, 31) == 0) plan_start(3'($urandom), 8'($urandom));
            else plan_tick(wire_tick());
        end
    endtask

    task automatic plan_op(input logic [2:0] cmd, input logic [7:0] wdata,
                           input logic [7:0] hi_byte, input logic [7:0] lo_byte,
                           input int nack, input logic [15:0] ready);
        sensor_bytes[0] = hi_byte;
        sensor_bytes[1] = lo_byte;
        sensor_bytes[2] = 8'($urandom);
        nack_pct = nack;
        ready_after = ready;
        plan_start(cmd, wdata);
        plan_to_idle();
    endtask

    task automatic plan_random_op();
        logic [2:0]  cmd;
        logic [15:0] ready;
        int          nack;
        if ($urandom_range(0, 9) == 0) cmd = 3'($urandom_range(CMD_SOFT_RST + 1, 7));
        else cmd = 3'($urandom_range(CMD_TEMP, CMD_SOFT_RST));
        nack = ($urandom_range(0, 4) == 0) ? 30 : 0;
        if (master_plan.wait_limit <= 16'd600 && $urandom_range(0, 5) == 0)
            ready = master_plan.wait_limit + 16'd1;
        else
            ready = 16'($urandom_range(0, 6));
        plan_op(cmd, 8'($urandom), pick_reading(), pick_reading(), nack, ready);
        repeat ($urandom_range(0, 3)) plan_tick(wire_tick());
    endtask

    task automatic wait_drained();
        while (tick_q.size() != 0 || i_s_tvalid || want_levels_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PHASE_TICKS) master_now.phase_ticks = val;
        else master_now.wait_limit = val;
        master_plan = master_now;
    endtask

    task automatic run_phase(input logic [15:0] ticks, input logic [15:0] limit, input int n);
        int stop;
        stop = planned + n;
        write_reg(CFG_PHASE_TICKS, ticks);
        write_reg(CFG_WAIT_LIMIT, limit);
        while (planned < stop) plan_random_op();
        wait_drained();
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                next_levels = advance_master(master_now, drv_tick);
                want_levels_q.push_back(next_levels);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left != 0 || tick_q.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end else begin
                    drv_tick = tick_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser <= drv_tick.action;
                    i_s_tdata <= {4'b0, drv_tick.din, drv_tick.wdata, drv_tick.cmd};
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                                 : $urandom_range(0, 24);
                    end
                end
            end
        end
    end

    // Receiver: switches between always ready, scattered stalls and longer stall blocks.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(50, 300);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   i_m_tready <= 1'b1;
                RX_SPOTTY: i_m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (rx_stall_left != 0) begin
                        i_m_tready <= 1'b0;
                        rx_stall_left--;
                    end else begin
                        i_m_tready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 10);
                    end
                end
            endcase
        end
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (want_levels_q.size() == 0) begin
                $error("result transfer %0h with nothing expected", o_m_tdata);
                err_cnt++;
            end else begin
                mon_want = want_levels_q.pop_front();
                mon_got = t_result'(o_m_tdata[$bits(t_result)-1:0]);
                cmp_field("sck", 8'(mon_want.sck), 8'(mon_got.sck));
                cmp_field("data_drive_low", 8'(mon_want.data_drive_low),
                          8'(mon_got.data_drive_low));
                cmp_field("busy_res", 8'(mon_want.busy_res), 8'(mon_got.busy_res));
                cmp_field("done_res", 8'(mon_want.done_res), 8'(mon_got.done_res));
                cmp_field("value", mon_want.value, mon_got.value);
                cmp_field("ack_error", 8'(mon_want.ack_error), 8'(mon_got.ack_error));
                cmp_field("ready_timeout", 8'(mon_want.ready_timeout),
                          8'(mon_got.ready_timeout));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[humidity_sensor_two_wire_master] ERROR");
            $finish;
        end
    end

    initial begin
        master_now = '0;
        master_now.phase_ticks = PHASE_TICKS_RST;
        master_now.wait_limit = WAIT_LIMIT_RST;
        master_plan = master_now;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        plan_tick(wire_tick());
        plan_tick(wire_tick());
        // Command codes past soft reset must leave the sequencer idle.
        for (int k = 1; k <= 3; k++) plan_start(3'(CMD_SOFT_RST + k), 8'($urandom));
        // A zero reading wraps to a negative temperature; all ones wraps the other way.
        plan_op(CMD_TEMP, 8'h00, 8'h00, 8'h00, 0, 16'd0);
        plan_op(CMD_TEMP, 8'hFF, 8'hFF, 8'hFF, 0, 16'd3);
        // Both sides of the humidity knee; random operations reach the other probes.
        plan_op(CMD_HUMID, 8'($urandom), 8'($urandom), HUM_KNEE, 0, 16'd1);
        plan_op(CMD_HUMID, 8'($urandom), 8'($urandom), HUM_KNEE + 8'd1, 0, 16'd1);
        plan_op(CMD_RD_STAT, 8'h00, 8'hA5, 8'h00, 100, 16'd0);
        plan_op(CMD_WR_STAT, 8'hFF, 8'h00, 8'h00, 0, 16'd0);
        plan_op(CMD_SOFT_RST, 8'h00, 8'h00, 8'h00, 0, 16'd0);
        wait_drained();

        // Zero in either register behaves as one.
        run_phase(16'd0, 16'd0, 50);
        run_phase(16'd2, 16'd2, 120);
        run_phase(16'd1, 16'd1, 50);

        // Longest phase: the phase length drops back to one before any boundary is reached.
        write_reg(CFG_PHASE_TICKS, 16'd65535);
        sensor_bytes[0] = pick_reading();
        sensor_bytes[1] = pick_reading();
        sensor_bytes[2] = 8'($urandom);
        nack_pct = 0;
        ready_after = 16'd2;
        plan_start(CMD_HUMID, 8'($urandom));
        repeat (20) plan_tick(wire_tick());
        wait_drained();
        write_reg(CFG_PHASE_TICKS, 16'd1);
        plan_to_idle();
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("[humidity_sensor_two_wire_master] OK");
        else
            $display("[humidity_sensor_two_wire_master] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/hstm_pkg.sv
design/hstm_convert.sv
design/humidity_sensor_two_wire_master.sv
verif/humidity_sensor_two_wire_master_tb.sv
